[design/bhw_pkg.sv]
// bhw_pkg: shared types and codes for the ber header walker
// holds the walker phase enum, status codes and the transfer payload structs
// no dependencies
package bhw_pkg;

   typedef enum logic [2:0] {
      PH_IDENT   = 3'd0,
      PH_HIGHTAG = 3'd1,
      PH_LENGTH  = 3'd2,
      PH_LONGLEN = 3'd3,
      PH_SKIP    = 3'd4,
      PH_HALT    = 3'd5
   } bhw_phase_type;

   localparam logic [2:0] ST_OK     = 3'd0;
   localparam logic [2:0] ST_INDEF  = 3'd1;
   localparam logic [2:0] ST_TRUNC  = 3'd2;
   localparam logic [2:0] ST_UNTERM = 3'd3;
   localparam logic [2:0] ST_NOLEN  = 3'd4;
   localparam logic [2:0] ST_BADLEN = 3'd5;

   localparam logic [4:0] TAG_HIGH_FORM = 5'h1F;
   localparam logic [6:0] LEN_MAX_OCTETS = 7'd8;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       run_start;
   } bhw_req_type;

   typedef struct packed {
      logic [31:0] record_number;
      logic [31:0] start_offset;
      logic [31:0] header_size;
      logic [1:0]  id_class;
      logic        constructed;
      logic [63:0] tag_number;
      logic [63:0] value_length;
      logic [2:0]  status;
   } bhw_rsp_type;

   typedef struct packed {
      logic        valid;
      bhw_rsp_type data;
   } bhw_emit_type;

endpackage

[design/ber_header_walker.sv]
// ber_header_walker: top level of the BER/DER TLV header walker
// holds the selection length register; uses bhw_pkg, bhw_in_stage, bhw_walker, bhw_out_stage
//
// Takes one byte of the selection per cycle and gives one record for each TLV header
// that completes or breaks. A byte transfer loads the input register; once the result
// register can take a record, the single-pass decode runs from the input register into
// the result register, which offers the record. The rate is one byte per cycle, set by
// the per-byte walker update, as long as no record waits on rsp_stall; while one waits,
// the input register still takes one more byte, then req_stall rises. Set csr_wr_data
// (selection length) while idle, and mark the first byte of each run with run_start.
// After an indefinite length or an error the walker drops bytes until the next run_start.
module ber_header_walker
   import bhw_pkg::*;
#(
   parameter int unsigned OFFSET_BITS = 32
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  bhw_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output bhw_rsp_type rsp_data,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   logic [31:0]  sel_length_ff;
   logic         advance;
   logic         out_ready;
   bhw_req_type  item;
   bhw_emit_type emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_length_ff <= '0;
      end else if (csr_wr_en) begin
         sel_length_ff <= csr_wr_data;
      end
   end

   bhw_in_stage u_in (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .out_ready (out_ready),
      .advance   (advance),
      .item      (item)
   );

   bhw_walker #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_walker (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .item       (item),
      .sel_length (sel_length_ff),
      .emit       (emit)
   );

   bhw_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .emit      (emit),
      .out_ready (out_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

[design/bhw_in_stage.sv]
// bhw_in_stage: input register of the header walker
// holds one accepted byte until the walker logic takes it; uses bhw_pkg
module bhw_in_stage
   import bhw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  bhw_req_type req_data,
   input  logic        out_ready,
   output logic        advance,
   output bhw_req_type item
);

   logic        valid_ff;
   logic        valid_in;
   bhw_req_type data_ff;
   logic        take;

   assign advance   = valid_ff && out_ready;
   assign req_stall = valid_ff && !out_ready;
   assign take      = req_valid && !req_stall;
   assign valid_in  = take ? 1'b1 : (advance ? 1'b0 : valid_ff);
   assign item      = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= req_data;
      end
   end

endmodule

[design/bhw_walker.sv]
// bhw_walker: walker state and single-pass decode of one byte
// decodes identifier, tag and length octets and skips value bytes; uses bhw_pkg
module bhw_walker
   import bhw_pkg::*;
#(
   parameter int unsigned OFFSET_BITS
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  bhw_req_type  item,
   input  logic [31:0]  sel_length,
   output bhw_emit_type emit
);

   typedef logic [OFFSET_BITS-1:0] pos_type;

   bhw_phase_type phase_ff, phase_in, cur_phase;
   pos_type       pos_ff, pos_in, cur_pos;
   pos_type       start_ff, start_in;
   pos_type       skip_ff, skip_in, skip_dec;
   logic [31:0]   count_ff, count_in, cur_count;
   logic [63:0]   tag_ff, tag_in;
   logic [1:0]    class_ff, class_in;
   logic          cons_ff, cons_in;
   logic [63:0]   lacc_ff, lacc_in;
   logic [3:0]    lbl_ff, lbl_in, lbl_dec;

   pos_type       len_clip, rem, consumed;
   logic [7:0]    b;
   logic [6:0]    cnt;
   logic          active, rem_zero, high_tag, cnt_bad, trunc, lbl_done;
   logic [63:0]   len_final;
   bhw_phase_type finish_phase;
   logic          emit_valid, bump;
   logic [2:0]    status;
   logic [63:0]   vlen;

   generate
      if (OFFSET_BITS >= 32) begin : g_wide
         assign len_clip = OFFSET_BITS'(sel_length);
      end else begin : g_clip
         assign len_clip = (|sel_length[31:OFFSET_BITS]) ? '1
                                                          : sel_length[OFFSET_BITS-1:0];
      end
   endgenerate

   assign b         = item.data_byte;
   assign cur_phase = item.run_start ? PH_IDENT : phase_ff;
   assign cur_pos   = item.run_start ? '0 : pos_ff;
   assign cur_count = item.run_start ? '0 : count_ff;

   assign active   = (cur_phase != PH_HALT) && (cur_pos < len_clip);
   assign consumed = cur_pos + pos_type'(1);
   assign rem      = len_clip - consumed;
   assign rem_zero = (consumed == len_clip);
   assign high_tag = (b[4:0] == TAG_HIGH_FORM);
   assign cnt      = b[6:0];
   assign cnt_bad  = (cnt > LEN_MAX_OCTETS) || (OFFSET_BITS'(cnt) > rem);
   assign lbl_dec  = lbl_ff - 4'd1;
   assign lbl_done = (lbl_dec == 4'd0);
   assign skip_dec = skip_ff - pos_type'(1);

   assign len_final = (cur_phase == PH_LENGTH) ? 64'(b) : {lacc_ff[55:0], b};
   assign trunc     = len_final > 64'(rem);
   assign finish_phase = trunc ? PH_HALT : ((len_final == 64'd0) ? PH_IDENT : PH_SKIP);

   // next phase
   always_comb begin
      phase_in = cur_phase;
      if (active) begin
         case (cur_phase)
            PH_IDENT: begin
               if (rem_zero) begin
                  phase_in = PH_HALT;
               end else if (high_tag) begin
                  phase_in = PH_HIGHTAG;
               end else begin
                  phase_in = PH_LENGTH;
               end
            end
            PH_HIGHTAG: begin
               if (rem_zero) begin
                  phase_in = PH_HALT;
               end else if (b[7]) begin
                  phase_in = PH_HIGHTAG;
               end else begin
                  phase_in = PH_LENGTH;
               end
            end
            PH_LENGTH: begin
               if (!b[7]) begin
                  phase_in = finish_phase;
               end else if (cnt == 7'd0 || cnt_bad) begin
                  phase_in = PH_HALT;
               end else begin
                  phase_in = PH_LONGLEN;
               end
            end
            PH_LONGLEN: begin
               phase_in = lbl_done ? finish_phase : PH_LONGLEN;
            end
            PH_SKIP: begin
               phase_in = (skip_dec == '0) ? PH_IDENT : PH_SKIP;
            end
            default: begin
               phase_in = PH_HALT;
            end
         endcase
      end
   end

   // datapath and result
   always_comb begin
      pos_in     = cur_pos;
      start_in   = start_ff;
      tag_in     = tag_ff;
      class_in   = class_ff;
      cons_in    = cons_ff;
      lacc_in    = lacc_ff;
      lbl_in     = lbl_ff;
      skip_in    = skip_ff;
      emit_valid = 1'b0;
      bump       = 1'b0;
      status     = ST_OK;
      vlen       = 64'd0;
      if (active) begin
         pos_in = consumed;
         case (cur_phase)
            PH_IDENT: begin
               start_in = cur_pos;
               class_in = b[7:6];
               cons_in  = b[5];
               tag_in   = high_tag ? 64'd0 : 64'(b[4:0]);
               if (rem_zero) begin
                  emit_valid = 1'b1;
                  status     = high_tag ? ST_UNTERM : ST_NOLEN;
               end
            end
            PH_HIGHTAG: begin
               tag_in = {tag_ff[56:0], b[6:0]};
               if (rem_zero) begin
                  emit_valid = 1'b1;
                  status     = b[7] ? ST_UNTERM : ST_NOLEN;
               end
            end
            PH_LENGTH: begin
               if (!b[7]) begin
                  lacc_in    = len_final;
                  emit_valid = 1'b1;
                  bump       = 1'b1;
                  status     = trunc ? ST_TRUNC : ST_OK;
                  vlen       = len_final;
                  if (!trunc) begin
                     skip_in = len_final[OFFSET_BITS-1:0];
                  end
               end else if (cnt == 7'd0) begin
                  emit_valid = 1'b1;
                  bump       = 1'b1;
                  status     = ST_INDEF;
               end else if (cnt_bad) begin
                  emit_valid = 1'b1;
                  status     = ST_BADLEN;
               end else begin
                  lacc_in = 64'd0;
                  lbl_in  = cnt[3:0];
               end
            end
            PH_LONGLEN: begin
               lacc_in = len_final;
               lbl_in  = lbl_dec;
               if (lbl_done) begin
                  emit_valid = 1'b1;
                  bump       = 1'b1;
                  status     = trunc ? ST_TRUNC : ST_OK;
                  vlen       = len_final;
                  if (!trunc) begin
                     skip_in = len_final[OFFSET_BITS-1:0];
                  end
               end
            end
            PH_SKIP: begin
               skip_in = skip_dec;
            end
            default: begin
               pos_in = consumed;
            end
         endcase
      end
      count_in = cur_count + 32'(bump);

      emit.valid              = emit_valid;
      emit.data.record_number = cur_count;
      emit.data.start_offset  = 32'(start_in);
      emit.data.header_size   = 32'(consumed - start_in);
      emit.data.id_class      = class_in;
      emit.data.constructed   = cons_in;
      emit.data.tag_number    = tag_in;
      emit.data.value_length  = vlen;
      emit.data.status        = status;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDENT;
         pos_ff   <= '0;
         start_ff <= '0;
         skip_ff  <= '0;
         count_ff <= '0;
         tag_ff   <= '0;
         class_ff <= '0;
         cons_ff  <= 1'b0;
         lacc_ff  <= '0;
         lbl_ff   <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         start_ff <= start_in;
         skip_ff  <= skip_in;
         count_ff <= count_in;
         tag_ff   <= tag_in;
         class_ff <= class_in;
         cons_ff  <= cons_in;
         lacc_ff  <= lacc_in;
         lbl_ff   <= lbl_in;
      end
   end

   a_halt_silent: assert property (@(posedge clock) disable iff (reset)
      advance && phase_ff == PH_HALT && !item.run_start |-> !emit.valid)
      else $error("record produced while walker halted");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      advance && emit.valid &&
      (emit.data.status == ST_OK || emit.data.status == ST_TRUNC ||
       emit.data.status == ST_INDEF)
      |=> count_ff == $past(cur_count) + 32'd1)
      else $error("record count did not advance after element");

   a_skip_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_SKIP |-> skip_ff != '0)
      else $error("value skip phase with zero bytes left");

   a_longlen_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_LONGLEN |-> lbl_ff != 4'd0 && lbl_ff <= 4'd8)
      else $error("long length octet count out of range");

endmodule

[design/bhw_out_stage.sv]
// bhw_out_stage: result register of the header walker
// holds one record until the rsp side takes it; uses bhw_pkg
module bhw_out_stage
   import bhw_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  bhw_emit_type emit,
   output logic         out_ready,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output bhw_rsp_type  rsp_data
);

   logic        valid_ff;
   logic        valid_in;
   bhw_rsp_type data_ff;
   logic        load;

   assign out_ready = !valid_ff || !rsp_stall;
   assign load      = advance && emit.valid;
   assign valid_in  = out_ready ? load : valid_ff;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= emit.data;
      end
   end

endmodule

[tb/bhw_record_checker.sv]
// bhw_record_checker: watches the byte, record and selection length ports of the walker
// keeps its own copy of the walker state, predicts each record and compares it field by field
// depends on bhw_pkg
module bhw_record_checker
   import bhw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  bhw_req_type req_data,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  bhw_rsp_type rsp_data,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,
   output int unsigned failures,
   output int unsigned pending,
   output int unsigned walked_bytes,
   output int unsigned records_seen
);

   localparam int unsigned REPORT_LIMIT = 10;

   bhw_phase_type walk_phase;
   logic [31:0]   sel_len;
   logic [31:0]   byte_pos;
   logic [31:0]   elem_start;
   logic [31:0]   elem_count;
   logic [31:0]   skip_count;
   logic [63:0]   tag_acc;
   logic [63:0]   len_acc;
   logic [1:0]    elem_class;
   logic          elem_cons;
   logic [3:0]    len_octets_left;
   bhw_rsp_type   expected_records[$];

   function automatic void clear_walk();
      walk_phase = PH_IDENT;
      byte_pos = '0;
      elem_start = '0;
      elem_count = '0;
      skip_count = '0;
      tag_acc = '0;
      len_acc = '0;
      elem_class = '0;
      elem_cons = 1'b0;
      len_octets_left = '0;
   endfunction

   function automatic bhw_rsp_type make_record(input logic [31:0] consumed,
                                               input logic [2:0] code,
                                               input logic [63:0] vlen);
      bhw_rsp_type rec;
      rec.record_number = elem_count;
      rec.start_offset = elem_start;
      rec.header_size = consumed - elem_start;
      rec.id_class = elem_class;
      rec.constructed = elem_cons;
      rec.tag_number = tag_acc;
      rec.value_length = vlen;
      rec.status = code;
      return rec;
   endfunction

   task automatic close_header(input logic [31:0] consumed, input logic [31:0] rem,
                               output bhw_rsp_type rec);
      if (len_acc > {32'b0, rem}) begin
         rec = make_record(consumed, ST_TRUNC, len_acc);
         walk_phase = PH_HALT;
      end else begin
         rec = make_record(consumed, ST_OK, len_acc);
         skip_count = len_acc[31:0];
         walk_phase = (len_acc == '0) ? PH_IDENT : PH_SKIP;
      end
      elem_count++;
   endtask

   task automatic walk_byte(input logic [7:0] b, input logic start, output bit walked,
                            output bit made, output bhw_rsp_type rec);
      logic [31:0] pos;
      logic [31:0] rem;
      logic [31:0] consumed;
      logic [6:0]  octets;
      walked = 1'b0;
      made = 1'b0;
      rec = '0;
      if (start) clear_walk();
      if (walk_phase != PH_HALT && byte_pos < sel_len) begin
         walked = 1'b1;
         pos = byte_pos;
         rem = sel_len - pos - 32'd1;
         consumed = pos + 32'd1;
         byte_pos = consumed;
         case (walk_phase)
            PH_IDENT: begin
               elem_start = pos;
               elem_class = b[7:6];
               elem_cons = b[5];
               tag_acc = {59'b0, b[4:0]};
               if (b[4:0] == TAG_HIGH_FORM) begin
                  tag_acc = '0;
                  if (rem == '0) begin
                     rec = make_record(consumed, ST_UNTERM, '0);
                     made = 1'b1;
                     walk_phase = PH_HALT;
                  end else begin
                     walk_phase = PH_HIGHTAG;
                  end
               end else if (rem == '0) begin
                  rec = make_record(consumed, ST_NOLEN, '0);
                  made = 1'b1;
                  walk_phase = PH_HALT;
               end else begin
                  walk_phase = PH_LENGTH;
               end
            end
            PH_HIGHTAG: begin
               tag_acc = {tag_acc[56:0], b[6:0]};
               if (b[7]) begin
                  if (rem == '0) begin
                     rec = make_record(consumed, ST_UNTERM, '0);
                     made = 1'b1;
                     walk_phase = PH_HALT;
                  end
               end else if (rem == '0) begin
                  rec = make_record(consumed, ST_NOLEN, '0);
                  made = 1'b1;
                  walk_phase = PH_HALT;
               end else begin
                  walk_phase = PH_LENGTH;
               end
            end
            PH_LENGTH: begin
               if (!b[7]) begin
                  len_acc = {56'b0, b};
                  close_header(consumed, rem, rec);
                  made = 1'b1;
               end else begin
                  octets = b[6:0];
                  if (octets == '0) begin
                     rec = make_record(consumed, ST_INDEF, '0);
                     made = 1'b1;
                     elem_count++;
                     walk_phase = PH_HALT;
                  end else if (octets > LEN_MAX_OCTETS || {25'b0, octets} > rem) begin
                     rec = make_record(consumed, ST_BADLEN, '0);
                     made = 1'b1;
                     walk_phase = PH_HALT;
                  end else begin
                     len_acc = '0;
                     len_octets_left = octets[3:0];
                     walk_phase = PH_LONGLEN;
                  end
               end
            end
            PH_LONGLEN: begin
               len_acc = {len_acc[55:0], b};
               len_octets_left--;
               if (len_octets_left == '0) begin
                  close_header(consumed, rem, rec);
                  made = 1'b1;
               end
            end
            PH_SKIP: begin
               skip_count--;
               if (skip_count == '0) walk_phase = PH_IDENT;
            end
            default: walk_phase = PH_HALT;
         endcase
      end
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got, inout bit bad);
      if (got !== want) begin
         bad = 1'b1;
         if (failures < REPORT_LIMIT)
            $display("tb: record %0d field %s expected %0h got %0h",
                     records_seen, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      bhw_rsp_type rec;
      bhw_rsp_type want;
      bit walked;
      bit made;
      bit bad;
      if (reset) begin
         clear_walk();
         sel_len = '0;
         expected_records.delete();
         failures = 0;
         walked_bytes = 0;
         records_seen = 0;
      end else begin
         if (csr_wr_en) sel_len = csr_wr_data;
         if (req_valid && !req_stall) begin
            walk_byte(req_data.data_byte, req_data.run_start, walked, made, rec);
            if (walked) walked_bytes++;
            if (made) expected_records.push_back(rec);
         end
         if (rsp_valid && !rsp_stall) begin
            records_seen++;
            if (expected_records.size() == 0) begin
               if (failures < REPORT_LIMIT)
                  $display("tb: record %0d arrived with none expected: %p",
                           records_seen, rsp_data);
               failures++;
            end else begin
               want = expected_records.pop_front();
               bad = 1'b0;
               check_field("record_number", want.record_number, rsp_data.record_number, bad);
               check_field("start_offset", want.start_offset, rsp_data.start_offset, bad);
               check_field("header_size", want.header_size, rsp_data.header_size, bad);
               check_field("id_class", want.id_class, rsp_data.id_class, bad);
               check_field("constructed", want.constructed, rsp_data.constructed, bad);
               check_field("tag_number", want.tag_number, rsp_data.tag_number, bad);
               check_field("value_length", want.value_length, rsp_data.value_length, bad);
               check_field("status", want.status, rsp_data.status, bad);
               if (bad) failures++;
            end
         end
      end
      pending = expected_records.size();
   end

endmodule

[tb/tb_top.sv]
// tb_top: stimulus and verdict for the ber header walker
// drives byte runs under several selection lengths with random idling on both channels;
// depends on bhw_pkg, ber_header_walker and bhw_record_checker
module tb_top;
   import bhw_pkg::*;

   localparam int unsigned BYTE_TARGET    = 1450;
   localparam int unsigned HOLD_CYCLES    = 200;
   localparam int unsigned DRAIN_CYCLES   = 6;
   localparam int unsigned WATCHDOG_LIMIT = 3000;
   localparam logic [31:0] SEL_MAX        = 32'hFFFF_FFFF;
   localparam logic [7:0]  LEN_INDEFINITE = 8'h80;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   bhw_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   bhw_rsp_type rsp_data;
   logic        csr_wr_en = 1'b0;
   logic [31:0] csr_wr_data = '0;

   int unsigned failures;
   int unsigned pending;
   int unsigned walked_bytes;
   int unsigned records_seen;
   int unsigned sent_bytes = 0;
   int unsigned settings_done = 0;
   int unsigned stuck_cycles = 0;
   int unsigned calm_left = 0;
   int unsigned stall_left = 0;
   int unsigned quiet_left = 0;
   bit          hold_req = 1'b0;
   bit          hold_done = 1'b0;
   logic [7:0]  run_bytes[$];

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   ber_header_walker DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   bhw_record_checker checker_inst (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .failures     (failures),
      .pending      (pending),
      .walked_bytes (walked_bytes),
      .records_seen (records_seen)
   );

   // record receiver: short and long stalls, quiet stretches, one long hold-off
   always @(negedge clock) begin
      int unsigned roll;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (hold_req && !hold_done) begin
         rsp_stall <= 1'b1;
         stall_left = HOLD_CYCLES - 1;
         hold_done = 1'b1;
      end else if (quiet_left > 0) begin
         rsp_stall <= 1'b0;
         quiet_left--;
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 3) begin
            rsp_stall <= 1'b0;
            quiet_left = $urandom_range(20, 80);
         end else if (roll < 6) begin
            rsp_stall <= 1'b1;
            stall_left = $urandom_range(8, 30);
         end else if (roll < 30) begin
            rsp_stall <= 1'b1;
            stall_left = $urandom_range(0, 2);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // offers run_bytes in order, holding each byte until its transfer
   task automatic send_run(input bit mark_start);
      int unsigned idle;
      int unsigned roll;
      foreach (run_bytes[i]) begin
         idle = 0;
         if (calm_left > 0) begin
            calm_left--;
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 4) calm_left = $urandom_range(20, 100);
            else if (roll < 7) idle = $urandom_range(8, 30);
            else if (roll < 35) idle = $urandom_range(1, 3);
         end
         if (idle > 0) begin
            req_valid <= 1'b0;
            repeat (idle) @(negedge clock);
         end
         req_valid <= 1'b1;
         req_data <= '{data_byte: run_bytes[i], run_start: (mark_start && i == 0)};
         @(posedge clock);
         while (req_stall) @(posedge clock);
         sent_bytes++;
         @(negedge clock);
      end
   endtask

   task automatic set_selection(input logic [31:0] value);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      settings_done++;
   endtask

   initial begin
      while (stuck_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            stuck_cycles = 0;
         else
            stuck_cycles++;
      end
      $display("tb: failure");
      $finish;
   end

   initial begin
      int unsigned phase_index;
      int unsigned roll;
      int unsigned budget;
      int unsigned mode;
      int unsigned groups;
      int unsigned octets;
      int unsigned vlen;
      logic [31:0] sel;
      logic [1:0]  cls;
      logic        cons;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // zero selection length out of reset: bytes are dropped
      run_bytes = '{8'hFF, 8'h00};
      send_run(1'b0);
      set_selection(32'd4);
      // no run start after reset, then indefinite length and a halted byte
      run_bytes = '{8'h05, 8'h00, 8'hE0, LEN_INDEFINITE, 8'h00};
      send_run(1'b0);
      // high tag still open at the end of the selection
      run_bytes = '{8'h1F, 8'h81, 8'h80, 8'h80};
      send_run(1'b1);
      // long length count beyond the bytes left
      run_bytes = '{8'h1F, 8'h05, 8'h82};
      send_run(1'b1);
      // identifier on the last byte, no length
      run_bytes = '{8'h04, 8'h01, 8'hAA, 8'h0C};
      send_run(1'b1);
      // value longer than the selection
      run_bytes = '{8'h04, 8'h7F};
      send_run(1'b1);
      // long form length, then a byte past the selection
      run_bytes = '{8'h02, 8'h81, 8'h01, 8'hAA, 8'h00};
      send_run(1'b1);

      phase_index = 0;
      while (sent_bytes < BYTE_TARGET) begin
         case (phase_index)
            0: sel = SEL_MAX;
            1: sel = '0;
            2: sel = 32'd1;
            default: begin
               roll = $urandom_range(0, 19);
               if (roll == 0) sel = '0;
               else if (roll == 1) sel = SEL_MAX;
               else if (roll == 2) sel = $urandom_range(1, 2);
               else if (roll < 5) sel = $urandom_range(60, 200);
               else sel = $urandom_range(3, 48);
            end
         endcase
         set_selection(sel);
         repeat ($urandom_range(2, 6)) begin
            if (sent_bytes >= BYTE_TARGET) break;
            if (!hold_req && sent_bytes > 600) hold_req = 1'b1;
            run_bytes.delete();
            if (sel == '0) budget = 4;
            else if (sel > 200) budget = $urandom_range(4, 60);
            else budget = sel;
            mode = $urandom_range(0, 9);
            if (sel == '0 || mode == 0) begin
               repeat ($urandom_range(1, (budget < 16) ? budget : 16))
                  run_bytes.push_back(8'($urandom));
            end else begin
               // broken runs stop at a random byte
               if (mode == 1) budget = $urandom_range(1, budget);
               while (run_bytes.size() < budget) begin
                  cls = 2'($urandom);
                  cons = 1'($urandom);
                  if ($urandom_range(0, 3) == 0) begin
                     groups = $urandom_range(1, 11);
                     run_bytes.push_back({cls, cons, TAG_HIGH_FORM});
                     for (int g = 1; g <= groups; g++)
                        run_bytes.push_back({(g < groups), 7'($urandom)});
                  end else begin
                     run_bytes.push_back({cls, cons, 5'($urandom_range(0, 30))});
                  end
                  roll = $urandom_range(0, 15);
                  if (roll == 0) begin
                     run_bytes.push_back(LEN_INDEFINITE);
                  end else if (roll == 1) begin
                     octets = $urandom_range(1, 12);
                     run_bytes.push_back({1'b1, 7'(octets)});
                     repeat (octets) run_bytes.push_back(8'($urandom));
                  end else begin
                     vlen = $urandom_range(0, 20);
                     if ($urandom_range(0, 1) == 0) begin
                        run_bytes.push_back({1'b0, 7'(vlen)});
                     end else begin
                        octets = $urandom_range(1, 8);
                        run_bytes.push_back({1'b1, 7'(octets)});
                        repeat (octets - 1) run_bytes.push_back(8'h00);
                        run_bytes.push_back(8'(vlen));
                     end
                     repeat (vlen) run_bytes.push_back(8'($urandom));
                  end
               end
               while (run_bytes.size() > budget) void'(run_bytes.pop_back());
            end
            if ($urandom_range(0, 4) == 0)
               repeat ($urandom_range(1, 3)) run_bytes.push_back(8'($urandom));
            send_run(1'b1);
         end
         phase_index++;
      end

      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("tb: walked %0d bytes and checked %0d records over %0d selection lengths,",
               walked_bytes, records_seen, settings_done);
      $display("tb: zero and the 32-bit maximum among them, with one long record hold-off");
      if (failures == 0 && pending == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

[files.f]
design/bhw_pkg.sv
design/bhw_in_stage.sv
design/bhw_walker.sv
design/bhw_out_stage.sv
design/ber_header_walker.sv
tb/bhw_record_checker.sv
tb/tb_top.sv
